FILE: design/tdvs_pkg.sv
// shared types and constants for the timed dosing valve sequencer
package tdvs_pkg;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_START = 4'b0010,
    PH_RUN   = 4'b0100,
    PH_END   = 4'b1000
  } phase_e;

  localparam logic [1:0] CAUSE_NONE    = 2'd0;
  localparam logic [1:0] CAUSE_COMMAND = 2'd1;
  localparam logic [1:0] CAUSE_PH      = 2'd2;
  localparam logic [1:0] CAUSE_EC      = 2'd3;

  localparam logic [2:0] REG_VOLUME = 3'd0;
  localparam logic [2:0] REG_FLOW   = 3'd1;
  localparam logic [2:0] REG_RATIO  = 3'd2;
  localparam logic [2:0] REG_PH_SEC = 3'd3;
  localparam logic [2:0] REG_LIMIT  = 3'd4;

  localparam int TDATA_IN_W  = 8;
  localparam int TDATA_OUT_W = 80;

  // item classified by the front end
  typedef struct packed {
    logic ec_req;
    logic ph_req;
    logic mix;
    logic lock_wr;
    logic lock_val;
    logic estop;
  } item_t;

endpackage

FILE: design/tdvs_front.sv
// input side: captures items into a two-entry queue
module tdvs_front import tdvs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_tvalid_i,
  output logic                  s_tready_o,
  input  logic [TDATA_IN_W-1:0] s_tdata_i,
  output logic                  q_valid_o,
  output item_t                 q_item_o,
  input  logic                  q_pop_i
);
  item_t       mem_q [2];
  logic        wp_q, rp_q;
  logic [1:0]  cnt_q;
  logic        push;

  assign s_tready_o = (cnt_q != 2'd2);
  assign push       = s_tvalid_i && s_tready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= '{ec_req: s_tdata_i[0], ph_req: s_tdata_i[1], mix: s_tdata_i[2],
                       lock_wr: s_tdata_i[3], lock_val: s_tdata_i[4],
                       estop: ~s_tdata_i[5]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (q_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i};
    end
  end

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_i |-> q_valid_o) else $error("pop from empty queue");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count overflow");
  a_full_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |-> !s_tready_o) else $error("accept while full");
endmodule

FILE: design/tdvs_div.sv
// restoring divider, one quotient bit a cycle
module tdvs_div #(
  parameter int NW = 40,
  parameter int DW = 23
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quo_o
);
  localparam int CW = $clog2(NW + 1);
  logic [NW-1:0] quo_q;
  logic [DW-1:0] rem_q;
  logic [DW-1:0] den_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;
  logic [DW:0]   trial;

  assign trial  = {rem_q, quo_q[NW-1]};
  assign quo_o  = quo_q;
  // pulses the cycle after the last quotient bit has been shifted in
  assign done_o = done_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_q <= DW'(trial - {1'b0, den_q});
        quo_q <= {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_q <= trial[DW-1:0];
        quo_q <= {quo_q[NW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == CW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) busy_q <= 1'b0;
      end
    end
  end
endmodule

FILE: design/tdvs_back.sv
// execution side: time computation, safety checks and the three sequencers
module tdvs_back import tdvs_pkg::*; #(
  parameter int TIMER_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [2:0]             cfg_idx_i,
  input  logic [31:0]            cfg_data_i,
  input  logic                   q_valid_i,
  input  item_t                  q_item_i,
  output logic                   q_pop_o,
  output logic                   m_tvalid_o,
  input  logic                   m_tready_i,
  output logic [TDATA_OUT_W-1:0] m_tdata_o
);
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_DA   = 5'b00010,
    ST_WA   = 5'b00100,
    ST_WB   = 5'b01000,
    ST_STEP = 5'b10000
  } ctl_e;

  localparam logic [TIMER_BITS-1:0] TMAX = '1;
  localparam int NW = 40;
  localparam int DW = 23;
  // compare width, wide enough for both the timers and the 32-bit limits
  localparam int LW = (TIMER_BITS > 32) ? TIMER_BITS : 32;

  logic [15:0] vol_q, flow_q, phs_q;
  logic [6:0]  ratio_q;
  logic [31:0] limit_q;

  logic ec_pend_q, ph_pend_q, locked_q, ec_seen_q, ph_seen_q, stale_q;
  logic va_q, vb_q, vp_q;
  logic [1:0] cause_q;
  phase_e pa_q, pb_q, pp_q;
  logic [TIMER_BITS-1:0] ea_q, eb_q, ep_q;
  logic [31:0] ta_q, tb_q;
  ctl_e st_q;
  item_t it_q;
  logic out_v_q;
  logic [TDATA_OUT_W-1:0] out_q;

  logic [6:0]  ratio_c, rat_new;
  logic [6:0]  share;
  logic [31:0] prod_q;
  logic [NW-1:0] num;
  logic [DW-1:0] den;
  logic div_start, div_done;
  logic [NW-1:0] quo;
  logic [31:0] quo_sat;

  assign ratio_c = (ratio_q > 7'd100) ? 7'd100 : ratio_q;
  assign rat_new = (cfg_data_i[6:0] > 7'd100) ? 7'd100 : cfg_data_i[6:0];
  assign share   = (st_q == ST_IDLE || st_q == ST_DA) ? ratio_c : 7'd100 - ratio_c;
  assign num     = NW'(prod_q) * NW'(60000);
  assign den     = DW'(flow_q) * DW'(100);
  assign quo_sat = (quo[NW-1:32] != '0) ? 32'hFFFF_FFFF : quo[31:0];
  assign div_start = (st_q == ST_DA) || (st_q == ST_WA && div_done);

  tdvs_div #(.NW(NW), .DW(DW)) u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(num), .den_i(den),
    .done_o(div_done), .quo_o(quo)
  );

  // share * volume is registered before the divider takes it
  always_ff @(posedge clk_i) begin
    prod_q <= 32'(share) * 32'(vol_q);
  end

  // one tick's worth of combinational update, starting from registered state
  logic n_ecp, n_php, n_lk, n_ecs, n_phs, n_va, n_vb, n_vp;
  logic [1:0] n_cause;
  phase_e n_pa, n_pb, n_pp;
  logic [TIMER_BITS-1:0] n_ea, n_eb, n_ep;
  logic [LW-1:0] lim_a, lim_b, lim_p, slim;

  assign lim_a = LW'(ta_q);
  assign lim_b = LW'(tb_q);
  assign lim_p = LW'(phs_q) * LW'(1000);
  assign slim  = LW'(limit_q);

  always_comb begin
    n_ecp = ec_pend_q | it_q.ec_req;
    n_php = ph_pend_q | it_q.ph_req;
    n_lk = locked_q; n_cause = cause_q;
    n_ecs = ec_seen_q; n_phs = ph_seen_q;
    n_va = va_q; n_vb = vb_q; n_vp = vp_q;
    n_pa = pa_q; n_pb = pb_q; n_pp = pp_q;
    n_ea = ea_q; n_eb = eb_q; n_ep = ep_q;
    if (it_q.lock_wr) begin
      n_lk = it_q.lock_val;
      n_cause = CAUSE_COMMAND;
    end
    if (va_q && ea_q != TMAX) n_ea = ea_q + 1'b1;
    if (vb_q && eb_q != TMAX) n_eb = eb_q + 1'b1;
    if (vp_q && ep_q != TMAX) n_ep = ep_q + 1'b1;
    if ((va_q && LW'(n_ea) >= slim) || (vb_q && LW'(n_eb) >= slim)) begin
      n_ecs = 1'b1; n_lk = 1'b1; n_cause = CAUSE_EC; n_ecp = 1'b0;
    end
    if (vp_q && LW'(n_ep) >= slim) begin
      n_phs = 1'b1; n_lk = 1'b1; n_cause = CAUSE_PH; n_php = 1'b0;
    end
    if (n_lk) begin
      n_pa = PH_END; n_pb = PH_END; n_pp = PH_END;
    end
    if (ratio_c != 7'd0) begin
      case (n_pa)
        PH_IDLE:  if (n_ecp && !n_lk) n_pa = PH_START;
        PH_START: begin n_va = 1'b1; n_ea = '0; n_pa = PH_RUN; end
        PH_RUN:   if (LW'(n_ea) > lim_a) begin n_ea = '0; n_pa = PH_END; end
        default:  begin n_va = 1'b0; n_ecp = 1'b0; n_pa = PH_IDLE; end
      endcase
      case (n_pb)
        PH_IDLE:  if (n_ecp && !n_lk) n_pb = PH_START;
        PH_START: begin n_vb = 1'b1; n_eb = '0; n_pb = PH_RUN; end
        PH_RUN:   if (LW'(n_eb) > lim_b) begin n_eb = '0; n_pb = PH_END; end
        default:  begin n_vb = 1'b0; n_ecp = 1'b0; n_pb = PH_IDLE; end
      endcase
    end
    if (phs_q != 16'd0) begin
      case (n_pp)
        PH_IDLE:  if (n_php && !n_lk) n_pp = PH_START;
        PH_START: begin n_vp = 1'b1; n_ep = '0; n_pp = PH_RUN; end
        PH_RUN:   if (LW'(n_ep) >= lim_p) begin n_ep = '0; n_pp = PH_END; end
        default:  begin n_vp = 1'b0; n_php = 1'b0; n_pp = PH_IDLE; end
      endcase
    end
  end

  assign q_pop_o    = (st_q == ST_IDLE) && q_valid_i && !out_v_q;
  assign m_tvalid_o = out_v_q;
  assign m_tdata_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (q_pop_o) it_q <= q_item_i;
    if (st_q == ST_STEP) begin
      out_q <= {6'd0, tb_q, ta_q, it_q.estop, n_phs, n_ecs, n_cause, n_lk,
                it_q.mix, n_vp, n_vb, n_va};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vol_q <= '0; flow_q <= '0; ratio_q <= '0; phs_q <= '0; limit_q <= 32'd120000;
      ec_pend_q <= 1'b0; ph_pend_q <= 1'b0; locked_q <= 1'b0; cause_q <= CAUSE_NONE;
      ec_seen_q <= 1'b0; ph_seen_q <= 1'b0; stale_q <= 1'b1;
      va_q <= 1'b0; vb_q <= 1'b0; vp_q <= 1'b0;
      pa_q <= PH_IDLE; pb_q <= PH_IDLE; pp_q <= PH_IDLE;
      ea_q <= '0; eb_q <= '0; ep_q <= '0; ta_q <= '0; tb_q <= '0;
      st_q <= ST_IDLE; out_v_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_VOLUME: vol_q <= cfg_data_i[15:0];
          REG_FLOW:   flow_q <= cfg_data_i[15:0];
          REG_RATIO: begin
            if (rat_new != ratio_c) stale_q <= 1'b1;
            ratio_q <= cfg_data_i[6:0];
          end
          REG_PH_SEC: phs_q <= cfg_data_i[15:0];
          REG_LIMIT:  limit_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_v_q && m_tready_i) out_v_q <= 1'b0;
      case (st_q)
        ST_IDLE: if (q_pop_o) st_q <= (flow_q != 16'd0 && stale_q) ? ST_DA : ST_STEP;
        ST_DA:   st_q <= ST_WA;
        ST_WA: if (div_done) begin
          ta_q <= quo_sat;
          st_q <= ST_WB;
        end
        ST_WB: if (div_done) begin
          tb_q <= quo_sat;
          stale_q <= 1'b0;
          st_q <= ST_STEP;
        end
        ST_STEP: begin
          ec_pend_q <= n_ecp; ph_pend_q <= n_php; locked_q <= n_lk; cause_q <= n_cause;
          ec_seen_q <= n_ecs; ph_seen_q <= n_phs;
          va_q <= n_va; vb_q <= n_vb; vp_q <= n_vp;
          pa_q <= n_pa; pb_q <= n_pb; pp_q <= n_pp;
          ea_q <= n_ea; eb_q <= n_eb; ep_q <= n_ep;
          out_v_q <= 1'b1;
          st_q <= ST_IDLE;
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> (st_q == ST_DA || st_q == ST_STEP)) else $error("bad pop");
  a_lock_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_STEP && n_lk) |=> (pa_q != PH_START && pp_q != PH_START))
    else $error("sequencer started under lockout");
  a_out_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_STEP) |-> !out_v_q) else $error("result overwritten before transfer");
endmodule

FILE: design/timed_dosing_valve_sequencer_top.sv
// top level of the timed dosing valve sequencer
// path: an input transfer is queued in the front end, popped in ST_IDLE and
// registered out of ST_STEP; ST_DA, ST_WA and ST_WB come between when both
// dose times are recomputed on the shared serial divider; the next item is
// popped only in ST_IDLE once the last result has been transferred
// reset: asynchronous active low, all sequencers idle, safety limit 120000 ms
module timed_dosing_valve_sequencer_top import tdvs_pkg::*; #(
  parameter int TIMER_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // ec_dose_request, ph_dose_request, mixture_run, lockout_write,
  // lockout_value, estop_pin_level, zero fill
  input  logic [TDATA_IN_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // valve_a_open, valve_b_open, valve_ph_open, valve_mix_open, lockout_active,
  // lockout_reason[2], ec_timeout_flag, ph_timeout_flag, estop_active,
  // time_a_ms[32], time_b_ms[32], zero fill[6]
  output logic [TDATA_OUT_W-1:0] m_axis_tdata,
  input  logic                   cfg_we_i,
  input  logic [2:0]             cfg_idx_i,
  input  logic [31:0]            cfg_data_i
);
  logic  q_valid, q_pop;
  item_t q_item;

  tdvs_front u_front (
    .clk_i, .rst_ni, .s_tvalid_i(s_axis_tvalid), .s_tready_o(s_axis_tready),
    .s_tdata_i(s_axis_tdata), .q_valid_o(q_valid), .q_item_o(q_item), .q_pop_i(q_pop)
  );

  tdvs_back #(.TIMER_BITS(TIMER_BITS)) u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .q_valid_i(q_valid), .q_item_i(q_item), .q_pop_o(q_pop),
    .m_tvalid_o(m_axis_tvalid), .m_tready_i(m_axis_tready), .m_tdata_o(m_axis_tdata)
  );
endmodule

FILE: tb/tb_timed_dosing_valve_sequencer_top.sv
// testbench for the timed dosing valve sequencer: predictor, scoreboard and stream drivers
`timescale 1ns / 1ps

module tb_timed_dosing_valve_sequencer_top;
  import tdvs_pkg::*;

  typedef struct packed {
    logic        va, vb, vph, vmix, lock;
    logic [1:0]  cause;
    logic        ec_to, ph_to, estop;
    logic [31:0] ta, tb;
  } tick_out_t;

  // state of the predicted sequencer
  class dosing_scoreboard;
    logic [15:0] volume, flow, ph_sec;
    logic [6:0]  ratio_reg;
    logic [31:0] limit;
    logic ec_pend, ph_pend, locked, ec_seen, ph_seen, stale, mix, va, vb, vph;
    phase_e ph_a, ph_b, ph_p;
    logic [1:0]  cause;
    logic [31:0] el_a, el_b, el_p, time_a, time_b;
    tick_out_t   pending_q[$];
    int          errors;

    function void clear();
      volume = 0; flow = 0; ratio_reg = 0; ph_sec = 0; limit = 120000;
      ec_pend = 0; ph_pend = 0; locked = 0; ec_seen = 0; ph_seen = 0;
      stale = 1; mix = 0; va = 0; vb = 0; vph = 0;
      ph_a = PH_IDLE; ph_b = PH_IDLE; ph_p = PH_IDLE; cause = CAUSE_NONE;
      el_a = 0; el_b = 0; el_p = 0; time_a = 0; time_b = 0;
      pending_q.delete(); errors = 0;
    endfunction

    function logic [6:0] clamp(logic [6:0] r);
      return (r > 100) ? 7'd100 : r;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] d);
      case (idx)
        REG_VOLUME: volume = d[15:0];
        REG_FLOW:   flow = d[15:0];
        REG_RATIO: begin
          if (clamp(d[6:0]) != clamp(ratio_reg)) stale = 1;
          ratio_reg = d[6:0];
        end
        REG_PH_SEC: ph_sec = d[15:0];
        REG_LIMIT:  limit = d;
        default: ;
      endcase
    endfunction

    function logic [31:0] dose_time(logic [6:0] share);
      logic [63:0] q;
      q = (64'(share) * 64'(volume) * 64'd60000) / (64'd100 * 64'(flow));
      return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    endfunction

    function logic [31:0] bump(logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 1;
    endfunction

    function void step_seq(ref phase_e ph, ref logic v, ref logic [31:0] el,
                           ref logic pend, input logic [63:0] lim, input logic strict);
      case (ph)
        PH_IDLE:  if (pend && !locked) ph = PH_START;
        PH_START: begin v = 1; el = 0; ph = PH_RUN; end
        PH_RUN: begin
          if (!(strict ? (64'(el) < lim) : (64'(el) <= lim))) begin
            el = 0; ph = PH_END;
          end
        end
        default: begin v = 0; pend = 0; ph = PH_IDLE; end
      endcase
    endfunction

    function void note_input(logic [5:0] f);
      tick_out_t o;
      logic [6:0] r;
      r = clamp(ratio_reg);
      if (f[0]) ec_pend = 1;
      if (f[1]) ph_pend = 1;
      if (f[3]) begin locked = f[4]; cause = CAUSE_COMMAND; end
      if (va) el_a = bump(el_a);
      if (vb) el_b = bump(el_b);
      if (vph) el_p = bump(el_p);
      if (va && el_a >= limit) begin ec_seen = 1; locked = 1; cause = CAUSE_EC; ec_pend = 0; end
      if (vb && el_b >= limit) begin ec_seen = 1; locked = 1; cause = CAUSE_EC; ec_pend = 0; end
      if (vph && el_p >= limit) begin ph_seen = 1; locked = 1; cause = CAUSE_PH; ph_pend = 0; end
      if (locked) begin ph_a = PH_END; ph_b = PH_END; ph_p = PH_END; end
      if (flow != 0 && stale) begin
        time_a = dose_time(r); time_b = dose_time(7'd100 - r); stale = 0;
      end
      if (r >= 1) begin
        step_seq(ph_a, va, el_a, ec_pend, 64'(time_a), 0);
        step_seq(ph_b, vb, el_b, ec_pend, 64'(time_b), 0);
      end
      if (ph_sec >= 1) step_seq(ph_p, vph, el_p, ph_pend, 64'(ph_sec) * 1000, 1);
      mix = f[2];
      o = '{va, vb, vph, mix, locked, cause, ec_seen, ph_seen, !f[5], time_a, time_b};
      pending_q.push_back(o);
    endfunction

    function void check_result(logic [TDATA_OUT_W-1:0] d);
      tick_out_t e, a;
      if (pending_q.size() == 0) begin
        $error("result with no expectation waiting"); errors++; return;
      end
      e = pending_q.pop_front();
      a = '{d[0], d[1], d[2], d[3], d[4], d[6:5], d[7], d[8], d[9], d[41:10], d[73:42]};
      if (a.va != e.va) begin $error("valve_a_open exp %0d got %0d", e.va, a.va); errors++; end
      if (a.vb != e.vb) begin $error("valve_b_open exp %0d got %0d", e.vb, a.vb); errors++; end
      if (a.vph != e.vph) begin $error("valve_ph_open exp %0d got %0d", e.vph, a.vph); errors++; end
      if (a.vmix != e.vmix) begin
        $error("valve_mix_open exp %0d got %0d", e.vmix, a.vmix); errors++;
      end
      if (a.lock != e.lock) begin
        $error("lockout_active exp %0d got %0d", e.lock, a.lock); errors++;
      end
      if (a.cause != e.cause) begin
        $error("lockout_reason exp %0d got %0d", e.cause, a.cause); errors++;
      end
      if (a.ec_to != e.ec_to) begin
        $error("ec_timeout_flag exp %0d got %0d", e.ec_to, a.ec_to); errors++;
      end
      if (a.ph_to != e.ph_to) begin
        $error("ph_timeout_flag exp %0d got %0d", e.ph_to, a.ph_to); errors++;
      end
      if (a.estop != e.estop) begin
        $error("estop_active exp %0d got %0d", e.estop, a.estop); errors++;
      end
      if (a.ta != e.ta) begin $error("time_a_ms exp %0d got %0d", e.ta, a.ta); errors++; end
      if (a.tb != e.tb) begin $error("time_b_ms exp %0d got %0d", e.tb, a.tb); errors++; end
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 600000;

  logic clk_i = 0, rst_ni = 0;
  logic s_axis_tvalid = 0, m_axis_tready = 0, cfg_we_i = 0;
  logic s_axis_tready, m_axis_tvalid;
  logic [TDATA_IN_W-1:0]  s_axis_tdata = '0;
  logic [TDATA_OUT_W-1:0] m_axis_tdata;
  logic [2:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic calm = 0;
  int cycles = 0;
  dosing_scoreboard sb;

  timed_dosing_valve_sequencer_top DUT (.*);

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timed_dosing_valve_sequencer_top verification failed");
      $finish;
    end
  end

  // result side: check every transfer, stall in random bursts
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  initial begin
    int gap;
    gap = 0;
    forever begin
      @(posedge clk_i);
      if (gap > 0) begin
        gap--; m_axis_tready <= 0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        gap = $urandom_range(1, 19); m_axis_tready <= 0;
      end else m_axis_tready <= 1;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] d);
    @(posedge clk_i);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_data_i <= d;
    sb.write_reg(idx, d);
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  // valid stays up between back-to-back ticks and drops only for idling
  task automatic send_tick(logic [5:0] f);
    if (!calm && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1; s_axis_tdata <= {2'b00, f};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_input(f);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  // mostly well-formed ticks: requests, rare lockout, pin mostly released
  function automatic logic [5:0] random_tick();
    logic [5:0] f;
    f = 6'($urandom);
    f[3] = ($urandom_range(0, 15) == 0);
    f[5] = ($urandom_range(0, 9) != 0);
    return f;
  endfunction

  task automatic run_phase(int n);
    repeat (n) send_tick(random_tick());
    drain();
  endtask

  initial begin
    sb = new();
    sb.clear();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    // directed: zero flow keeps times, ratio and pH disabled
    send_tick(6'b100001);
    send_tick(6'b000000);
    send_tick(6'b111111);
    send_tick(6'b101000);
    drain();
    write_reg(REG_VOLUME, 32'd1);
    write_reg(REG_FLOW, 32'd1);
    write_reg(REG_RATIO, 32'd50);
    write_reg(REG_PH_SEC, 32'd0);
    write_reg(REG_LIMIT, 32'd4);
    // short limit: nutrient timeout, then release
    repeat (10) send_tick(6'b100001);
    send_tick(6'b101000);
    repeat (3) send_tick(6'b100011);
    drain();
    // ratio above 100, huge volume, smallest flow: long time, still below saturation
    write_reg(REG_RATIO, 32'h7F);
    write_reg(REG_VOLUME, 32'hFFFF);
    write_reg(REG_LIMIT, 32'hFFFF_FFFF);
    write_reg(REG_PH_SEC, 32'd1);
    repeat (6) send_tick(6'b100011);
    drain();
    // pH timeout with tiny limit
    write_reg(REG_LIMIT, 32'd1);
    write_reg(REG_PH_SEC, 32'hFFFF);
    repeat (5) send_tick(6'b100010);
    send_tick(6'b001000);
    drain();
    // random phases through several settings
    for (int p = 0; p < 8; p++) begin
      write_reg(REG_VOLUME, $urandom_range(0, 3) == 0 ? 32'hFFFF : $urandom_range(0, 20));
      write_reg(REG_FLOW, $urandom_range(0, 4) == 0 ? 32'd0 : $urandom_range(1, 65535));
      write_reg(REG_RATIO, $urandom_range(0, 127));
      write_reg(REG_PH_SEC, $urandom_range(0, 2) == 0 ? 32'd0 : 32'd1);
      write_reg(REG_LIMIT, $urandom_range(0, 1) ? $urandom_range(1, 30) : 32'd1500);
      send_tick(6'b101000);
      if (p == 7) calm = 1;
      run_phase(48);
    end
    if (sb.errors == 0) $display("timed_dosing_valve_sequencer_top verification clean");
    else $display("timed_dosing_valve_sequencer_top verification failed");
    $finish;
  end
endmodule
